>>> src/cms_pkg.sv
// Package for the stylesheet minifier: character codes, state and result types, step functions.
`default_nettype none

package cms_pkg;

  // Scanner modes.
  typedef enum logic [1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_COMMENT = 2'd1,
    MODE_STRING  = 2'd2
  } cms_mode_t;

  // Character codes that the scanner looks for.
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // At most three words come out of one input byte.
  localparam int RES_SLOTS = 3;
  localparam int RES_CNT_W = $clog2(RES_SLOTS + 1);

  // Scanner state carried from one byte to the next.
  typedef struct packed {
    cms_mode_t   scan_mode;
    logic [7:0]  quote_char;
    logic [7:0]  held_byte;
    logic        held_valid;
    logic [7:0]  prior_input_byte;
    logic        skip_next;
    logic [7:0]  last_emitted;
    logic        emitted_any;
    logic        space_pending;
    logic        last_was_space;
  } cms_state_t;

  localparam cms_state_t STATE_RESET = '0;

  // One output word.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       text_done;
  } cms_result_t;

  // Working set while one byte is processed: state plus the words made so far.
  typedef struct packed {
    cms_state_t                    st;
    cms_result_t [RES_SLOTS-1:0]   res;
    logic [RES_CNT_W-1:0]          n;
  } cms_work_t;

  // Append a byte to the word list and note it as the last emitted byte.
  function automatic cms_work_t put_byte(input cms_work_t w_in, input logic [7:0] b);
    cms_work_t w;
    w = w_in;
    if (w.n < RES_CNT_W'(RES_SLOTS)) begin
      w.res[w.n[RES_CNT_W-1:0]] = '{out_byte: b, has_byte: 1'b1, text_done: 1'b0};
      w.n = w.n + RES_CNT_W'(1);
    end
    w.st.last_emitted = b;
    w.st.emitted_any  = 1'b1;
    return w;
  endfunction

  // Emit the pending space, if any.
  function automatic cms_work_t flush_space(input cms_work_t w_in);
    cms_work_t w;
    w = w_in;
    if (w.st.space_pending) begin
      w.st.space_pending = 1'b0;
      w = put_byte(w, CH_SPACE);
    end
    return w;
  endfunction

  // Space, tab, line feed, vertical tab, form feed or carriage return.
  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // An ordinary byte: pending space first, then the byte itself.
  function automatic cms_work_t plain_char(input cms_work_t w_in, input logic [7:0] c);
    cms_work_t w;
    w = flush_space(w_in);
    w = put_byte(w, c);
    w.st.last_was_space = 1'b0;
    return w;
  endfunction

  // Handle one byte afresh in the current mode.
  function automatic cms_work_t handle(input cms_work_t w_in, input logic [7:0] c,
                                       input logic last);
    cms_work_t w;
    w = w_in;
    if (w.st.scan_mode == MODE_COMMENT) begin
      // Inside a comment only a star matters, and it waits for the next byte.
      if (c == CH_STAR && !last) begin
        w.st.held_byte  = c;
        w.st.held_valid = 1'b1;
      end
    end else if (w.st.scan_mode == MODE_STRING) begin
      // Strings go through untouched; an escaped quote does not close them.
      w = flush_space(w);
      w = put_byte(w, c);
      if (c == w.st.quote_char && w.st.prior_input_byte != CH_BSLASH) begin
        w.st.scan_mode = MODE_NORMAL;
      end
    end else if (c == CH_SLASH && !last) begin
      // A slash may open a comment, so it is held for one byte.
      w.st.held_byte  = c;
      w.st.held_valid = 1'b1;
    end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
      w = flush_space(w);
      w = put_byte(w, c);
      w.st.scan_mode  = MODE_STRING;
      w.st.quote_char = c;
    end else if (is_ws(c)) begin
      // A whitespace run becomes one pending space, except after punctuation.
      if (!w.st.last_was_space && w.st.emitted_any &&
          w.st.last_emitted != CH_LBRACE && w.st.last_emitted != CH_RBRACE &&
          w.st.last_emitted != CH_SEMI && w.st.last_emitted != CH_COLON) begin
        w.st.space_pending  = 1'b1;
        w.st.last_was_space = 1'b1;
      end
    end else begin
      if (c == CH_SEMI) begin
        w.st.space_pending = 1'b0;
      end
      w = plain_char(w, c);
      if (c == CH_COLON) begin
        w.st.skip_next = 1'b1;
      end
    end
    return w;
  endfunction

  // Full processing of one input byte, including the end of a text.
  function automatic cms_work_t step(input cms_state_t st, input logic [7:0] b,
                                     input logic last);
    cms_work_t w;
    w.st  = st;
    w.res = '0;
    w.n   = '0;
    if (w.st.held_valid) begin
      w.st.held_valid = 1'b0;
      if (w.st.scan_mode == MODE_COMMENT) begin
        if (b == CH_SLASH) begin
          w.st.scan_mode = MODE_NORMAL;
        end else begin
          w = handle(w, b, last);
        end
      end else if (b == CH_STAR) begin
        w.st.scan_mode = MODE_COMMENT;
      end else begin
        w = plain_char(w, w.st.held_byte);
        w = handle(w, b, last);
      end
    end else if (w.st.skip_next) begin
      w.st.skip_next = 1'b0;
      if (b != CH_SPACE) begin
        w = handle(w, b, last);
      end
    end else begin
      w = handle(w, b, last);
    end
    w.st.prior_input_byte = b;

    // End of text: flush the space, always give a final word, start afresh.
    if (last) begin
      w = flush_space(w);
      if (w.n == '0) begin
        w.res[0] = '0;
        w.n      = RES_CNT_W'(1);
      end
      w.res[w.n - RES_CNT_W'(1)].text_done = 1'b1;
      w.st = STATE_RESET;
    end
    return w;
  endfunction

endpackage

`default_nettype wire

>>> src/css_minify_stream.sv
// Streaming stylesheet minifier: scanner state, step logic and a four-word result queue.
`default_nettype none

// Takes stylesheet text one byte per word and gives a minified copy, one byte per output
// word: comments are removed, quoted strings pass unchanged, whitespace runs collapse to one
// space and spaces after braces, semicolons and colons are dropped. The word that marks the
// end of a text carries text_done, and when no byte is due then it comes with has_byte low;
// each text starts from a clean state. A byte is processed in the cycle it is accepted and
// its words appear from the next cycle. One input byte gives zero to three output words, and
// the output side moves one word per cycle when not stalled, so the block takes one byte per
// cycle while each byte yields at most one word and the output is not stalled. The four-word
// result queue sets this: a byte is accepted while the queue holds at most one word, also
// while that word waits on a stalled output.
module css_minify_stream (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] text_byte,
  input  wire logic       end_of_text,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            has_byte,
  output logic            text_done
);
  import cms_pkg::*;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  cms_state_t                   st;
  cms_work_t                    work;
  cms_result_t [FIFO_DEPTH-1:0] fifo;
  logic [PTR_W-1:0]             rd_ptr;
  logic [PTR_W-1:0]             wr_ptr;
  logic [CNT_W-1:0]             count;
  logic                         in_accept;
  logic                         out_accept;
  logic [RES_CNT_W-1:0]         push_n;

  // Step logic for the byte on the input port.
  always_comb begin
    work = step(st, text_byte, end_of_text);
  end

  // Handshakes: room for a full set of words is needed before a byte is taken.
  assign in_stall   = (count > CNT_W'(FIFO_DEPTH - RES_SLOTS));
  assign in_accept  = in_valid && !in_stall;
  assign out_valid  = (count != '0);
  assign out_accept = out_valid && !out_stall;
  assign push_n     = in_accept ? work.n : '0;

  // Head of the result queue drives the output.
  assign out_byte  = fifo[rd_ptr].out_byte;
  assign has_byte  = fifo[rd_ptr].has_byte;
  assign text_done = fifo[rd_ptr].text_done;

  // Scanner state and queue control.
  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= STATE_RESET;
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (in_accept) begin
        st <= work.st;
      end
      wr_ptr <= wr_ptr + PTR_W'(push_n);
      rd_ptr <= rd_ptr + PTR_W'(out_accept);
      count  <= count + CNT_W'(push_n) - CNT_W'(out_accept);
    end
  end

  // Queue storage: up to three words written per cycle at consecutive places.
  always_ff @(posedge clk) begin
    for (int i = 0; i < RES_SLOTS; i++) begin
      if (RES_CNT_W'(i) < push_n) begin
        fifo[PTR_W'(wr_ptr + PTR_W'(i))] <= work.res[i];
      end
    end
  end

  // The queue never overfills.
  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  // After the final byte of a text the scanner is back in its reset state.
  assert property (@(posedge clk) disable iff (rst)
                   (in_accept && end_of_text) |=> (st == STATE_RESET))
    else $error("scanner state not cleared at end of text");

  // A word without a byte only ever closes a text.
  assert property (@(posedge clk) disable iff (rst)
                   (out_valid && !has_byte) |-> text_done)
    else $error("empty word that does not end a text");

  // A word without a byte carries a zero byte field.
  assert property (@(posedge clk) disable iff (rst)
                   (out_valid && !has_byte) |-> (out_byte == 8'h00))
    else $error("empty word with non-zero byte");

endmodule

`default_nettype wire

>>> sim/cms_checker.sv
// Checker for the stylesheet minifier: predicts the output words and compares them.
`timescale 1ns / 1ps

module cms_checker (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       in_stall,
  input  wire logic [7:0] text_byte,
  input  wire logic       end_of_text,
  input  wire logic       out_valid,
  input  wire logic       out_stall,
  input  wire logic [7:0] out_byte,
  input  wire logic       has_byte,
  input  wire logic       text_done,
  output int              fail_count,
  output int              words_left,
  output int              words_checked
);
  import cms_pkg::*;

  // One minified output word as the scanner is expected to produce it.
  typedef struct packed {
    logic [7:0] ch;
    logic       has_ch;
    logic       done;
  } out_word_t;

  out_word_t due_words[$];
  out_word_t step_words[$];

  // Scanner state of the prediction.
  cms_mode_t  mode;
  logic [7:0] quote_ch;
  logic [7:0] held_ch;
  logic       held_on;
  logic [7:0] prev_in;
  logic       skip_space;
  logic [7:0] last_out;
  logic       emitted;
  logic       space_due;
  logic       after_ws;

  // A fresh text starts with every state entry cleared.
  function automatic void clear_scan();
    mode       = MODE_NORMAL;
    quote_ch   = '0;
    held_ch    = '0;
    held_on    = 1'b0;
    prev_in    = '0;
    skip_space = 1'b0;
    last_out   = '0;
    emitted    = 1'b0;
    space_due  = 1'b0;
    after_ws   = 1'b0;
  endfunction

  function automatic void emit_char(input logic [7:0] c);
    out_word_t w;
    w.ch     = c;
    w.has_ch = 1'b1;
    w.done   = 1'b0;
    step_words.insert(step_words.size(), w);
    last_out = c;
    emitted  = 1'b1;
  endfunction

  function automatic void emit_pending_space();
    if (space_due) begin
      space_due = 1'b0;
      emit_char(CH_SPACE);
    end
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic void copy_char(input logic [7:0] c);
    emit_pending_space();
    emit_char(c);
    after_ws = 1'b0;
  endfunction

  // Treats one byte on its own merits in the current mode.
  function automatic void scan_char(input logic [7:0] c, input logic fin);
    if (mode == MODE_COMMENT) begin
      // Only a star can start the end of a comment, and it needs a successor.
      if (c == CH_STAR && !fin) begin
        held_ch = c;
        held_on = 1'b1;
      end
    end else if (mode == MODE_STRING) begin
      emit_pending_space();
      emit_char(c);
      if (c == quote_ch && prev_in != CH_BSLASH) begin
        mode = MODE_NORMAL;
      end
    end else if (c == CH_SLASH && !fin) begin
      held_ch = c;
      held_on = 1'b1;
    end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
      emit_pending_space();
      emit_char(c);
      mode     = MODE_STRING;
      quote_ch = c;
    end else if (is_blank(c)) begin
      // A run of blanks turns into one space, but never after punctuation.
      if (!after_ws && emitted && last_out != CH_LBRACE && last_out != CH_RBRACE &&
          last_out != CH_SEMI && last_out != CH_COLON) begin
        space_due = 1'b1;
        after_ws  = 1'b1;
      end
    end else begin
      if (c == CH_SEMI) begin
        space_due = 1'b0;
      end
      copy_char(c);
      if (c == CH_COLON) begin
        skip_space = 1'b1;
      end
    end
  endfunction

  // Works out every word that one accepted input byte gives and queues them.
  function automatic void predict_char(input logic [7:0] c, input logic fin);
    out_word_t w;
    int        last_idx;
    step_words.delete();
    if (held_on) begin
      held_on = 1'b0;
      if (mode == MODE_COMMENT) begin
        if (c == CH_SLASH) begin
          mode = MODE_NORMAL;
        end else begin
          scan_char(c, fin);
        end
      end else if (c == CH_STAR) begin
        mode = MODE_COMMENT;
      end else begin
        copy_char(held_ch);
        scan_char(c, fin);
      end
    end else if (skip_space) begin
      skip_space = 1'b0;
      if (c != CH_SPACE) begin
        scan_char(c, fin);
      end
    end else begin
      scan_char(c, fin);
    end
    prev_in = c;

    // The end of a text always yields a marked word, possibly an empty one.
    if (fin) begin
      emit_pending_space();
      if (step_words.size() == 0) begin
        w.ch     = 8'h00;
        w.has_ch = 1'b0;
        w.done   = 1'b0;
        step_words.insert(0, w);
      end
      last_idx = step_words.size() - 1;
      w = step_words[last_idx];
      w.done = 1'b1;
      step_words[last_idx] = w;
      clear_scan();
    end
    foreach (step_words[i]) begin
      due_words.insert(due_words.size(), step_words[i]);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
    $display("%0t: output word %0d: %s expected %02h, got %02h",
             $realtime, words_checked, what, want, got);
    fail_count++;
  endtask

  // Output words are checked before the byte of the same edge is predicted,
  // since that byte's words can only appear from the next cycle.
  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      clear_scan();
      due_words.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (due_words.size() == 0) begin
          report_mismatch("word with none due, out_byte", 8'h00, out_byte);
        end else begin
          want = due_words.pop_front();
          if (out_byte !== want.ch) begin
            report_mismatch("out_byte", want.ch, out_byte);
          end
          if (has_byte !== want.has_ch) begin
            report_mismatch("has_byte", {7'd0, want.has_ch}, {7'd0, has_byte});
          end
          if (text_done !== want.done) begin
            report_mismatch("text_done", {7'd0, want.done}, {7'd0, text_done});
          end
        end
        words_checked++;
      end
      if (in_valid && !in_stall) begin
        predict_char(text_byte, end_of_text);
      end
    end
    words_left = due_words.size();
  end

endmodule

>>> sim/tb_css_minify_stream.sv
// Testbench top for the stylesheet minifier: builds texts, drives both handshakes, gives the verdict.
`timescale 1ns / 1ps

module tb_css_minify_stream;
  import cms_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 500;
  localparam int MAX_IDLE     = 18;
  localparam int SETTLE       = 20;

  // One input word: a text byte and its end-of-text mark.
  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
  } text_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] text_byte = 8'h00;
  logic       end_of_text = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       text_done;

  text_item_t items[$];
  int         texts_built = 0;
  int         items_sent = 0;
  int         cycle_count = 0;
  int         fail_count;
  int         words_left;
  int         words_checked;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  css_minify_stream u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .text_byte  (text_byte),
    .end_of_text(end_of_text),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .has_byte   (has_byte),
    .text_done  (text_done)
  );

  cms_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .text_byte    (text_byte),
    .end_of_text  (end_of_text),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .has_byte     (has_byte),
    .text_done    (text_done),
    .fail_count   (fail_count),
    .words_left   (words_left),
    .words_checked(words_checked)
  );

  task automatic add_char(input logic [7:0] c);
    text_item_t w;
    w.ch  = c;
    w.eot = 1'b0;
    items.insert(items.size(), w);
  endtask

  task automatic add_string(input string s);
    foreach (s[i]) begin
      add_char(s[i]);
    end
  endtask

  // Marks the most recent byte as the last one of its text.
  task automatic end_text();
    text_item_t w;
    int         last_idx;
    last_idx = items.size() - 1;
    w = items[last_idx];
    w.eot = 1'b1;
    items[last_idx] = w;
    texts_built++;
  endtask

  // Appends one stylesheet-like token with random content.
  task automatic add_token();
    logic [7:0] blanks[6];
    logic [7:0] puncts[4];
    logic [7:0] q;
    int         n;
    blanks = '{CH_SPACE, CH_TAB, 8'h0A, 8'h0B, 8'h0C, CH_CR};
    puncts = '{CH_LBRACE, CH_RBRACE, CH_SEMI, CH_COLON};
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        n = $urandom_range(1, 6);
        repeat (n) add_char(8'($urandom_range(8'h61, 8'h7A)));
        if ($urandom_range(0, 3) == 0) add_char(8'($urandom_range(8'h23, 8'h2E)));
      end
      3: begin
        n = $urandom_range(1, 3);
        repeat (n) add_char(blanks[$urandom_range(0, 5)]);
      end
      4: add_char(puncts[$urandom_range(0, 3)]);
      5: begin
        add_char(CH_COLON);
        if ($urandom_range(0, 3) != 0) add_char(CH_SPACE);
        if ($urandom_range(0, 3) == 0) add_char(CH_SPACE);
        add_char(8'($urandom_range(8'h30, 8'h39)));
      end
      6: begin
        // Comment, possibly with stars and slashes inside.
        add_char(CH_SLASH);
        add_char(CH_STAR);
        n = $urandom_range(0, 5);
        repeat (n) begin
          case ($urandom_range(0, 3))
            0: add_char(CH_STAR);
            1: add_char(CH_SLASH);
            default: add_char(8'($urandom_range(0, 255)));
          endcase
        end
        add_char(CH_STAR);
        add_char(CH_SLASH);
      end
      7: begin
        // Quoted string, with escaped quotes and the other quote inside.
        q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
        add_char(q);
        n = $urandom_range(0, 5);
        repeat (n) begin
          case ($urandom_range(0, 4))
            0: begin
              add_char(CH_BSLASH);
              add_char(q);
            end
            1: add_char(q == CH_DQUOTE ? CH_SQUOTE : CH_DQUOTE);
            2: add_char(blanks[$urandom_range(0, 5)]);
            default: add_char(8'($urandom_range(8'h20, 8'h7E)));
          endcase
        end
        add_char(q);
      end
      8: add_char($urandom_range(0, 1) ? CH_SLASH : CH_STAR);
      default: add_char(8'($urandom_range(0, 255)));
    endcase
  endtask

  // A random text, now and then cut short inside a comment or string.
  task automatic build_random_text();
    int start;
    int n;
    int cut;
    start = items.size();
    n = $urandom_range(1, 10);
    repeat (n) add_token();
    if ($urandom_range(0, 4) == 0) begin
      cut = $urandom_range(1, 3);
      while (cut > 0 && items.size() > start + 1) begin
        items.delete(items.size() - 1);
        cut--;
      end
    end
    end_text();
  endtask

  // Sends every queued word, with random gaps and stretches of none.
  task automatic send_items();
    text_item_t w;
    int         gap;
    logic       calm;
    calm = 1'b0;
    while (items.size() > 0) begin
      w = items.pop_front();
      if ($urandom_range(0, 29) == 0) calm = !calm;
      gap = (calm || $urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_valid    <= 1'b1;
      text_byte   <= w.ch;
      end_of_text <= w.eot;
      do @(posedge clk); while (in_stall);
      items_sent++;
      @(negedge clk);
    end
    in_valid <= 1'b0;
  endtask

  // Output side: stalls at random before each word.
  initial begin : out_side
    int   hold;
    logic calm;
    calm = 1'b0;
    do @(negedge clk); while (rst);
    forever begin
      if ($urandom_range(0, 29) == 0) calm = !calm;
      hold = (calm || $urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, MAX_IDLE);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Watchdog on the total run length.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run stopped after %0d cycles with %0d words outstanding.",
             cycle_count, words_left);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    int directed_count;

    // Extremes of the byte, a cancelled space, the space skipped after a colon.
    add_char(8'h00);
    add_char(CH_TAB);
    add_char(CH_SEMI);
    add_char(8'hFF);
    add_char(CH_COLON);
    add_char(CH_SPACE);
    add_char("x");
    add_char(CH_CR);
    add_char(CH_RBRACE);
    end_text();
    // Empty comment, string with an escaped quote, and a slash as the last byte.
    add_string("/**/\"\\\"\"/");
    end_text();
    // Whitespace after a string is dropped when a space came before it;
    // the text ends in a comment with a star that has no successor.
    add_string("a \"\" /**");
    end_text();
    // Text that ends inside a string.
    add_string("'x");
    end_text();
    // Text with nothing to emit.
    add_char(CH_SPACE);
    end_text();
    directed_count = items.size();

    while (items.size() < directed_count + RANDOM_ITEMS) begin
      build_random_text();
    end

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    send_items();

    while (words_left != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    $display("Fed %0d text bytes in %0d texts (directed and random) with random idling.",
             items_sent, texts_built);
    $display("Checked %0d minified words, %0d mismatches.", words_checked, fail_count);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
src/cms_pkg.sv
src/css_minify_stream.sv
sim/cms_checker.sv
sim/tb_css_minify_stream.sv
